// File: rtl/core/tbh_pkg.sv
// ----------------------------------------------------------------------------
// tbh_pkg
// Shared types and constants for the tabulated bit hash byte generator.
// ----------------------------------------------------------------------------
package tbh_pkg;

    // table geometry
    localparam int TBL_DEPTH = 8;
    localparam int BYTE_W    = 8;
    localparam int SEED_W    = TBL_DEPTH * BYTE_W;

    // configuration port
    localparam int CFG_IDX_W = 1;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef t_byte [TBL_DEPTH-1:0] t_tbl;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED = 1'b0,
        CFG_MODE = 1'b1
    } t_cfg_idx;

    // tabulation term selection
    typedef enum logic {
        MODE_PLAIN  = 1'b0,
        MODE_SQUARE = 1'b1
    } t_tab_mode;

endpackage

// File: rtl/core/tbh_hash.sv
// ----------------------------------------------------------------------------
// tbh_hash
// One tabulated bit hash of a byte: start sum plus one term per input bit,
// all mod 256. Eight parallel terms feed a short adder chain.
// ----------------------------------------------------------------------------
module tbh_hash (
    input  tbh_pkg::t_tbl      i_tbl,
    input  tbh_pkg::t_byte     i_cur,
    input  tbh_pkg::t_byte     i_sum,
    input  tbh_pkg::t_tab_mode i_mode,
    output tbh_pkg::t_byte     o_value
);

    tbh_pkg::t_byte             term [tbh_pkg::TBL_DEPTH];
    tbh_pkg::t_byte             base [tbh_pkg::TBL_DEPTH];
    tbh_pkg::t_byte             sq   [tbh_pkg::TBL_DEPTH];
    tbh_pkg::t_byte             acc;

    // per-bit terms; the square of -(e+i) equals the square of (e+i)
    always_comb begin
        for (int i = 0; i < tbh_pkg::TBL_DEPTH; i++) begin
            base[i] = i_tbl[i] + tbh_pkg::BYTE_W'(i)
                    + {{(tbh_pkg::BYTE_W-1){1'b0}}, i_cur[i]};
            sq[i]   = base[i] * base[i];
            if (i_mode == tbh_pkg::MODE_SQUARE) begin
                term[i] = sq[i];
            end else begin
                term[i] = i_cur[i] ? i_tbl[i] : '0;
            end
        end
    end

    // sum of start value and terms, wrapping at one byte
    always_comb begin
        acc = i_sum;
        for (int i = 0; i < tbh_pkg::TBL_DEPTH; i++) begin
            acc = acc + term[i];
        end
    end

    assign o_value = acc;

endmodule

// File: rtl/core/tabulated_bit_hash_byte_generator.sv
// ----------------------------------------------------------------------------
// tabulated_bit_hash_byte_generator
// Pseudo-random byte stream from an eight-entry tabulated bit hash.
// ----------------------------------------------------------------------------
// Every input word on the slave stream yields exactly one output byte. A word
// with bit 0 of tdata set (restart) first reloads the table, start sum and
// current byte from the seed registers, then produces a byte. The hash, the
// table shift and the byte itself are done in the cycle the word is accepted,
// so one word per cycle is taken while the skid slot is free; the result goes
// to the output register, or to the skid slot if the output is held. The
// eight term units and adder chain are combinational. A two-deep output stage
// lets the slave side keep accepting while a byte waits on the master side.
// Configuration writes (seed, mode) are taken at any time but are meant to
// happen while the stream is idle; a new seed acts at the next restart, a new
// mode from the next word on.
// ----------------------------------------------------------------------------
module tabulated_bit_hash_byte_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [0] restart, [7:1] zero
    // master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // [7:0] value
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tbh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tbh_pkg::SEED_W-1:0]      i_cfg_data
);

    // configuration registers
    tbh_pkg::t_tbl      r_seed;
    tbh_pkg::t_byte     r_seed_sum;
    tbh_pkg::t_tab_mode r_mode;
    tbh_pkg::t_byte     n_seed_sum;

    // generator state
    tbh_pkg::t_tbl      r_tbl;
    tbh_pkg::t_byte     r_sum;
    tbh_pkg::t_byte     r_cur;

    // output stage
    logic               r_out_vld, n_out_vld;
    logic               r_skid_vld, n_skid_vld;
    tbh_pkg::t_byte     r_out, n_out;
    tbh_pkg::t_byte     r_skid, n_skid;

    logic               in_fire;
    logic               out_fire;
    logic               restart;
    tbh_pkg::t_tbl      src_tbl;
    tbh_pkg::t_byte     src_sum;
    tbh_pkg::t_byte     src_cur;
    tbh_pkg::t_byte     nxt;
    tbh_pkg::t_tbl      cfg_bytes;

    assign o_cfg_ready = 1'b1;
    assign cfg_bytes   = tbh_pkg::t_tbl'(i_cfg_data);

    // byte sum of the incoming seed, kept ready for restarts
    always_comb begin
        n_seed_sum = '0;
        for (int i = 0; i < tbh_pkg::TBL_DEPTH; i++) begin
            n_seed_sum = n_seed_sum + cfg_bytes[i];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_seed_sum <= '0;
            r_mode     <= tbh_pkg::MODE_PLAIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tbh_pkg::CFG_SEED: begin
                    r_seed     <= cfg_bytes;
                    r_seed_sum <= n_seed_sum;
                end
                tbh_pkg::CFG_MODE: begin
                    r_mode <= tbh_pkg::t_tab_mode'(i_cfg_data[0]);
                end
                default: begin
                end
            endcase
        end
    end

    // handshakes
    assign s_axis_tready = !r_skid_vld;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = r_out_vld && m_axis_tready;
    assign restart       = s_axis_tdata[0];

    // hash source: seed on restart, running state otherwise
    assign src_tbl = restart ? r_seed     : r_tbl;
    assign src_sum = restart ? r_seed_sum : r_sum;
    assign src_cur = restart ? r_seed_sum : r_cur;

    tbh_hash u_hash (
        .i_tbl   (src_tbl),
        .i_cur   (src_cur),
        .i_sum   (src_sum),
        .i_mode  (r_mode),
        .o_value (nxt)
    );

    // table shift and state update on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl <= '0;
            r_sum <= '0;
            r_cur <= '0;
        end else if (in_fire) begin
            for (int i = 1; i < tbh_pkg::TBL_DEPTH; i++) begin
                r_tbl[i] <= src_tbl[i-1];
            end
            r_tbl[0] <= nxt;
            r_sum    <= src_sum;
            r_cur    <= nxt;
        end
    end

    // output register with skid slot
    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (in_fire) begin
            if (!r_out_vld || out_fire) begin
                n_out     = nxt;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = nxt;
                n_skid_vld = 1'b1;
            end
        end else if (out_fire) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    // the skid slot only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word without output word");

    // entry 0 of the table always mirrors the current byte
    a_tbl_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tbl[0] == r_cur)
        else $error("table head differs from current byte");

    // a restart takes the precomputed seed sum as start sum
    a_restart_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && restart) |=> (r_sum == $past(r_seed_sum)))
        else $error("start sum not reloaded on restart");

    // an accepted word always lands as the newest output byte
    a_word_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> ((r_skid_vld && r_skid == r_cur) || (!r_skid_vld && r_out == r_cur)))
        else $error("generated byte lost");

endmodule
